>>> design/rthp_pkg.sv
// Shared types and constants for the RTP header parser.
package rthp_pkg;

   localparam int unsigned MAX_PACKET_BYTES = 65535;
   localparam logic [15:0] MAX_COUNT = 16'(MAX_PACKET_BYTES);
   localparam logic [15:0] FIXED_HEADER_BYTES = 16'd12;
   localparam logic [1:0] HDR_VERSION = 2'd2;
   localparam int unsigned EXT_BIT = 4;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_PARSE_ERROR = 2'd2,
      STATUS_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] byte_count;
      logic [7:0] first_header_byte;
      logic [6:0] type_bits;
      logic [15:0] seq_capture;
      logic [31:0] time_capture;
      logic [31:0] source_capture;
      logic [15:0] extension_words;
      logic length_overflow;
   } header_state_type;

   typedef struct packed {
      status_type status;
      logic [6:0] media_type;
      logic [15:0] sequence_number;
      logic [31:0] timestamp;
      logic [31:0] source_id;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
   } result_type;

endpackage

>>> design/rthp_check.sv
// Header length and status checks on the state of a finished packet.
module rthp_check import rthp_pkg::*; (
   input header_state_type hdr,
   output result_type result
);

   logic [3:0] csrc_count;
   logic has_ext;
   logic [15:0] hdr_bytes;
   logic [15:0] remaining;
   logic [15:0] ext_room;
   logic [17:0] ext_total;
   logic [15:0] final_len;
   status_type status;

   always_comb begin
      csrc_count = hdr.first_header_byte[3:0];
      has_ext = hdr.first_header_byte[EXT_BIT];
      hdr_bytes = FIXED_HEADER_BYTES + {10'd0, csrc_count, 2'b00};
      remaining = hdr.byte_count - hdr_bytes;
      ext_room = remaining - 16'd4;
      ext_total = {2'b00, hdr_bytes} + 18'd4 + {hdr.extension_words, 2'b00};
      final_len = has_ext ? ext_total[15:0] : hdr_bytes;

      priority if (hdr.length_overflow) begin
         status = STATUS_TOO_LONG;
      end else if (hdr.byte_count < FIXED_HEADER_BYTES) begin
         status = STATUS_SHORT;
      end else if (hdr.first_header_byte[7:6] != HDR_VERSION) begin
         status = STATUS_PARSE_ERROR;
      end else if (hdr_bytes > hdr.byte_count) begin
         status = STATUS_PARSE_ERROR;
      end else if (has_ext && (remaining < 16'd4)) begin
         status = STATUS_PARSE_ERROR;
      end else if (has_ext && (hdr.extension_words > {2'b00, ext_room[15:2]})) begin
         status = STATUS_PARSE_ERROR;
      end else begin
         status = STATUS_OK;
      end

      result = '0;
      result.status = status;
      if (status == STATUS_OK) begin
         result.media_type = hdr.type_bits;
         result.sequence_number = hdr.seq_capture;
         result.timestamp = hdr.time_capture;
         result.source_id = hdr.source_capture;
         result.payload_offset = final_len;
         result.payload_length = hdr.byte_count - final_len;
      end
   end

endmodule

>>> design/rtp_header_parser.sv
// Top level of the RTP fixed header parser, one packet byte per word.
// The last byte is held in the input register, then its result is written into the result register.
// Throughput: one byte per cycle; input ready drops only while a last byte
// waits in the input register for the result register to be taken.
// Reset is synchronous and active high; it clears all packet state and empties both registers.
module rtp_header_parser import rthp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_data_byte,
   input logic req_last_byte,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic [6:0] rsp_media_type,
   output logic [15:0] rsp_sequence_number,
   output logic [31:0] rsp_timestamp,
   output logic [31:0] rsp_source_id,
   output logic [15:0] rsp_payload_offset,
   output logic [15:0] rsp_payload_length
);

   logic in_valid_ff;
   logic [7:0] in_data_ff;
   logic in_last_ff;
   header_state_type state_ff;
   header_state_type state_in;
   logic rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic rsp_free;
   logic stage_free;
   logic process;
   logic [15:0] pos;
   logic [15:0] csrc_end;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign stage_free = !in_last_ff || rsp_free;
   assign process = in_valid_ff && stage_free;
   assign req_ready = !in_valid_ff || stage_free;

   always_comb begin
      state_in = state_ff;
      pos = state_ff.byte_count;
      csrc_end = FIXED_HEADER_BYTES + {10'd0, state_ff.first_header_byte[3:0], 2'b00};
      if (!state_ff.length_overflow) begin
         if (pos >= MAX_COUNT) begin
            state_in.length_overflow = 1'b1;
         end else begin
            state_in.byte_count = pos + 16'd1;
            priority if (pos == 16'd0) begin
               state_in.first_header_byte = in_data_ff;
            end else if (pos == 16'd1) begin
               state_in.type_bits = in_data_ff[6:0];
            end else if (pos < 16'd4) begin
               state_in.seq_capture = {state_ff.seq_capture[7:0], in_data_ff};
            end else if (pos < 16'd8) begin
               state_in.time_capture = {state_ff.time_capture[23:0], in_data_ff};
            end else if (pos < 16'd12) begin
               state_in.source_capture = {state_ff.source_capture[23:0], in_data_ff};
            end else if (state_ff.first_header_byte[EXT_BIT] &&
                         ((pos == csrc_end + 16'd2) || (pos == csrc_end + 16'd3))) begin
               state_in.extension_words = {state_ff.extension_words[7:0], in_data_ff};
            end else begin
               state_in.byte_count = pos + 16'd1;
            end
         end
      end
   end

   rthp_check u_check (
      .hdr(state_in),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
            in_data_ff <= req_data_byte;
            in_last_ff <= req_last_byte;
         end else if (process) begin
            in_valid_ff <= 1'b0;
         end
         if (process) begin
            state_ff <= in_last_ff ? '0 : state_in;
         end
         if (process && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= result;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_media_type = rsp_ff.media_type;
   assign rsp_sequence_number = rsp_ff.sequence_number;
   assign rsp_timestamp = rsp_ff.timestamp;
   assign rsp_source_id = rsp_ff.source_id;
   assign rsp_payload_offset = rsp_ff.payload_offset;
   assign rsp_payload_length = rsp_ff.payload_length;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (process && in_last_ff) |=> (state_ff == '0))
      else $error("Packet state was not cleared after the last byte.");

   a_overflow_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.length_overflow |-> (state_ff.byte_count == MAX_COUNT))
      else $error("Overflow flag set with the byte count below its limit.");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && in_last_ff && rsp_valid_ff))
      else $error("Input stalled without a last byte waiting on a full result register.");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STATUS_OK)) |->
      ((rsp_ff.payload_offset == 16'd0) && (rsp_ff.payload_length == 16'd0) &&
       (rsp_ff.timestamp == 32'd0)))
      else $error("Header fields not zero on an error result.");

   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_OK)) |->
      (rsp_ff.payload_offset >= FIXED_HEADER_BYTES))
      else $error("Payload offset below the fixed header length.");

endmodule
